// ===== src/tkd_pkg.sv =====
// shared types and constants for the touch key dimmer debounce block
// no dependencies; used by the key lanes, the merge stage and the top level
package tkd_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int KEY_COUNT      = 3;
  localparam int CFG_WIDTH      = 16;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd18;
  localparam logic [CFG_WIDTH-1:0] REPEAT_RESET   = 16'd25;

  // key lane order
  localparam int KEY_POWER = 0;
  localparam int KEY_UP    = 1;
  localparam int KEY_DOWN  = 2;

  // register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_REPEAT   = 1'b1;

  // brightness step codes
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  typedef struct packed {
    logic press;
    logic stable;
  } lane_out_t;

  typedef struct packed {
    logic       power_toggle;
    logic [1:0] dim_step;
    logic [2:0] stable_keys;
  } result_t;

endpackage

// ===== src/tkd_key_lane.sv =====
// one debounce lane: last raw level, change stamp and stable level of one key
// depends on tkd_pkg
module tkd_key_lane #(
  parameter int TIME_WIDTH = tkd_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           raw,
  input  logic [TIME_WIDTH-1:0]          now,
  input  logic [tkd_pkg::CFG_WIDTH-1:0]  debounce_ms,
  output tkd_pkg::lane_out_t             lane_out
);

  logic                  last_raw;
  logic                  stable_level;
  logic [TIME_WIDTH-1:0] change_stamp;

  logic                  changed;
  logic [TIME_WIDTH-1:0] stamp_eff;
  logic [TIME_WIDTH-1:0] held;
  logic                  fire;

  always_comb begin
    changed   = raw != last_raw;
    stamp_eff = changed ? now : change_stamp;
    held      = now - stamp_eff;
    fire      = (held >= TIME_WIDTH'(debounce_ms)) && (stable_level != raw);
    lane_out.stable = fire ? raw : stable_level;
    lane_out.press  = fire & raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      stable_level <= 1'b0;
      change_stamp <= '0;
    end else if (accept) begin
      last_raw     <= raw;
      stable_level <= lane_out.stable;
      change_stamp <= stamp_eff;
    end
  end

endmodule

// ===== src/tkd_merge.sv =====
// merge stage: combines the key lanes into toggle and step requests,
// keeps the repeat timer and holds results in a two-entry output buffer
// depends on tkd_pkg
module tkd_merge #(
  parameter int TIME_WIDTH = tkd_pkg::TIME_WIDTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         accept,
  input  logic [TIME_WIDTH-1:0]                        now,
  input  logic [tkd_pkg::CFG_WIDTH-1:0]                repeat_ms,
  input  tkd_pkg::lane_out_t [tkd_pkg::KEY_COUNT-1:0]  lanes,
  output logic                                         in_ready,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output tkd_pkg::result_t                             out_data
);

  logic [TIME_WIDTH-1:0] repeat_stamp;
  logic [TIME_WIDTH-1:0] repeat_stamp_next;
  logic [TIME_WIDTH-1:0] rs_eff;
  logic                  repeat_due;
  logic                  su;
  logic                  sd;
  logic [1:0]            step;
  tkd_pkg::result_t      result;

  logic                  skid_valid;
  tkd_pkg::result_t      skid_data;

  always_comb begin
    su   = lanes[tkd_pkg::KEY_UP].stable;
    sd   = lanes[tkd_pkg::KEY_DOWN].stable;
    priority if (lanes[tkd_pkg::KEY_UP].press && !sd) begin
      step   = tkd_pkg::STEP_UP;
      rs_eff = now;
    end else if (lanes[tkd_pkg::KEY_DOWN].press && !su) begin
      step   = tkd_pkg::STEP_DOWN;
      rs_eff = now;
    end else begin
      step   = tkd_pkg::STEP_NONE;
      rs_eff = repeat_stamp;
    end
    repeat_due = (now - rs_eff) >= TIME_WIDTH'(repeat_ms);
    repeat_stamp_next = rs_eff;
    // exactly one of up and down held: auto-repeat, else timer restarts
    priority if (su && !sd) begin
      if (repeat_due) begin
        step              = tkd_pkg::STEP_UP;
        repeat_stamp_next = now;
      end
    end else if (sd && !su) begin
      if (repeat_due) begin
        step              = tkd_pkg::STEP_DOWN;
        repeat_stamp_next = now;
      end
    end else begin
      repeat_stamp_next = now;
    end
    result.power_toggle = lanes[tkd_pkg::KEY_POWER].press;
    result.dim_step     = step;
    result.stable_keys  = {sd, su, lanes[tkd_pkg::KEY_POWER].stable};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_stamp <= '0;
    end else if (accept) begin
      repeat_stamp <= repeat_stamp_next;
    end
  end

  assign in_ready = !skid_valid;

  // skid entry takes a beat that arrives while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a beat while output is empty");

  a_no_bad_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.dim_step != 2'd3)
    else $error("invalid dim step code");

  a_both_held_no_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stable_keys[1] && out_data.stable_keys[2])
      |-> out_data.dim_step == tkd_pkg::STEP_NONE)
    else $error("step issued while up and down both held");

  a_up_needs_up_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dim_step == tkd_pkg::STEP_UP)
      |-> (out_data.stable_keys[1] && !out_data.stable_keys[2]))
    else $error("up step without up held alone");

  a_skid_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> skid_valid)
    else $error("skid beat lost while output stalled");
`endif

endmodule

// ===== src/touch_key_dimmer_debounce.sv =====
// output: an accepted scan's result is registered in the output register, or in
// the skid entry, which absorbs one stalled beat; throughput: one scan per cycle
// while in_ready is high; key lanes and the repeat timer update on each accepted scan
// reset: synchronous active-high rst clears all key state and the repeat timer,
// loads debounce_ms = 18 and repeat_ms = 25, and empties the output buffer
module touch_key_dimmer_debounce #(
  parameter int TIME_WIDTH = tkd_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // scan input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        power_raw,
  input  logic        up_raw,
  input  logic        down_raw,
  input  logic [31:0] now_ms,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        power_toggle,
  output logic [1:0]  dim_step,
  output logic [2:0]  stable_keys,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [tkd_pkg::CFG_WIDTH-1:0] debounce_ms;
  logic [tkd_pkg::CFG_WIDTH-1:0] repeat_ms;
  logic                          cfg_write;
  logic                          accept;
  logic [TIME_WIDTH-1:0]         now;
  logic [tkd_pkg::KEY_COUNT-1:0] raw_keys;
  tkd_pkg::lane_out_t [tkd_pkg::KEY_COUNT-1:0] lanes;
  tkd_pkg::result_t              out_data;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= tkd_pkg::DEBOUNCE_RESET;
      repeat_ms   <= tkd_pkg::REPEAT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        tkd_pkg::REG_DEBOUNCE: debounce_ms <= pwdata[tkd_pkg::CFG_WIDTH-1:0];
        tkd_pkg::REG_REPEAT:   repeat_ms   <= pwdata[tkd_pkg::CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tkd_pkg::REG_DEBOUNCE: prdata = 32'(debounce_ms);
      tkd_pkg::REG_REPEAT:   prdata = 32'(repeat_ms);
      default:               prdata = '0;
    endcase
  end

  assign accept   = in_valid & in_ready;
  assign now      = now_ms[TIME_WIDTH-1:0];
  assign raw_keys = {down_raw, up_raw, power_raw};

  for (genvar k = 0; k < tkd_pkg::KEY_COUNT; k++) begin : g_lane
    tkd_key_lane #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .accept      (accept),
      .raw         (raw_keys[k]),
      .now         (now),
      .debounce_ms (debounce_ms),
      .lane_out    (lanes[k])
    );
  end

  tkd_merge #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .now       (now),
    .repeat_ms (repeat_ms),
    .lanes     (lanes),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign power_toggle = out_data.power_toggle;
  assign dim_step     = out_data.dim_step;
  assign stable_keys  = out_data.stable_keys;

endmodule
